FILE: src/tty_ld_pkg.sv
// ---------------------------------------------------------------------------
// tty_ld_pkg
// Shared types and constants of the terminal line discipline.
// ---------------------------------------------------------------------------
package tty_ld_pkg;

   localparam int unsigned RingDepthDef = 4096;
   localparam int unsigned LineDepthDef = 256;

   localparam int unsigned CmdWidth  = 1;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned KindWidth = 3;
   localparam int unsigned CsrIdxWidth = 3;

   // result kinds
   localparam logic [KindWidth-1:0] KindEcho  = 3'd0;
   localparam logic [KindWidth-1:0] KindIntr  = 3'd1;
   localparam logic [KindWidth-1:0] KindSusp  = 3'd2;
   localparam logic [KindWidth-1:0] KindData  = 3'd3;
   localparam logic [KindWidth-1:0] KindEmpty = 3'd4;
   localparam logic [KindWidth-1:0] KindEof   = 3'd5;

   // commands
   localparam logic [CmdWidth-1:0] CmdRx   = 1'b0;
   localparam logic [CmdWidth-1:0] CmdRead = 1'b1;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] RegInputMode = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegLocalMode = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegIntrChar  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegSuspChar  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegEraseChar = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegKillChar  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] RegEofChar   = 3'd6;

   // characters
   localparam logic [7:0] ChBs    = 8'h08;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChNl    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChSp    = 8'h20;
   localparam logic [7:0] ChCaret = 8'h5E;
   localparam logic [7:0] ChU     = 8'h55;
   localparam logic [7:0] ChDel   = 8'h7F;
   localparam logic [7:0] CtlOffs = 8'h40;

   typedef struct packed {
      logic [2:0] input_mode;
      logic [4:0] local_mode;
      logic [7:0] intr_char;
      logic [7:0] susp_char;
      logic [7:0] erase_char;
      logic [7:0] kill_char;
      logic [7:0] eof_char;
   } cfg_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [7:0]           data;
   } res_type;

endpackage

FILE: src/tty_ld_if.sv
// ---------------------------------------------------------------------------
// tty_ld channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ---------------------------------------------------------------------------
interface tty_ld_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;
   modport source (output valid, cmd, rx_byte, input ready);
   modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface tty_ld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic       last;
   modport source (output valid, kind, data, last, input ready);
   modport sink   (input valid, kind, data, last, output ready);
endinterface

interface tty_ld_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: src/tty_ld_csr.sv
// ---------------------------------------------------------------------------
// tty_ld_csr
// Configuration register file of the line discipline.
// ---------------------------------------------------------------------------
module tty_ld_csr (
   input  logic                clock,
   input  logic                reset,
   tty_ld_csr_if.sink          csr,
   output tty_ld_pkg::cfg_type cfg
);
   import tty_ld_pkg::*;

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_mode <= 3'd1;
         cfg_ff.local_mode <= 5'd31;
         cfg_ff.intr_char  <= 8'h03;
         cfg_ff.susp_char  <= 8'h1A;
         cfg_ff.erase_char <= 8'h7F;
         cfg_ff.kill_char  <= 8'h15;
         cfg_ff.eof_char   <= 8'h04;
      end else if (csr.valid) begin
         unique case (csr.index)
            RegInputMode: cfg_ff.input_mode <= csr.wdata[2:0];
            RegLocalMode: cfg_ff.local_mode <= csr.wdata[4:0];
            RegIntrChar:  cfg_ff.intr_char  <= csr.wdata;
            RegSuspChar:  cfg_ff.susp_char  <= csr.wdata;
            RegEraseChar: cfg_ff.erase_char <= csr.wdata;
            RegKillChar:  cfg_ff.kill_char  <= csr.wdata;
            RegEofChar:   cfg_ff.eof_char   <= csr.wdata;
            default: ;
         endcase
      end
   end
endmodule

FILE: src/tty_canonical_line_discipline.sv
// ---------------------------------------------------------------------------
// tty_canonical_line_discipline
// Terminal input line discipline with canonical line editing.
// ---------------------------------------------------------------------------
// Usage: the req channel carries a command (0 received byte, 1 read one
// byte) and the byte. Each request gives zero to three rsp transactions;
// the last one of a request has last set. The csr channel writes the
// mode and special character registers and is always ready; write it
// only while the block is idle.
// Timing: a request is decoded when it is taken, and each response
// then waits in the output register until the sink takes it. A newline
// or end of file that commits a line copies the line into the read ring
// through one shared copy unit, one byte per cycle.
// req ready is low while a request is in work.
// Reset empties the ring and the line, clears the end of file flag and
// loads the register defaults. The stores need no clearing pass.
// A stalled rsp holds its output register and the sequencer waits.
// ---------------------------------------------------------------------------
module tty_canonical_line_discipline #(
   parameter int unsigned RING_DEPTH = tty_ld_pkg::RingDepthDef,
   parameter int unsigned LINE_DEPTH = tty_ld_pkg::LineDepthDef
) (
   input logic          clock,
   input logic          reset,
   tty_ld_req_if.sink   req,
   tty_ld_rsp_if.source rsp,
   tty_ld_csr_if.sink   csr
);
   import tty_ld_pkg::*;

   localparam int unsigned RW = $clog2(RING_DEPTH);
   localparam int unsigned LW = $clog2(LINE_DEPTH);
   localparam int unsigned LCW = $clog2(LINE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EMIT, ST_COPY, ST_COPYW, ST_RDWAIT
   } state_type;

   cfg_type cfg;
   tty_ld_csr u_csr (.clock(clock), .reset(reset), .csr(csr), .cfg(cfg));

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] line_mem [LINE_DEPTH];

   state_type     state_ff;
   logic [RW-1:0] head_ff, tail_ff;
   logic [LCW-1:0] len_ff, cpy_ff;
   logic          eof_ff;
   res_type       res_ff [3];
   logic [1:0]    nres_ff, ridx_ff;
   logic          commit_ff;
   logic          rsp_valid_ff;
   logic [7:0]    line_rd_ff, ring_rd_ff;

   // decode of the received byte
   logic [7:0] c0, c1, c2, c;
   logic       sig_en, canon, echo, ign;
   assign sig_en = cfg.local_mode[0];
   assign canon  = cfg.local_mode[1];
   assign echo   = cfg.local_mode[2];
   assign c0 = req.rx_byte;
   assign c1 = (cfg.input_mode[0] && c0 == ChCr) ? ChNl : c0;
   assign c2 = (cfg.input_mode[1] && c1 == ChNl) ? ChCr : c1;
   assign ign = cfg.input_mode[2] && c2 == ChCr;
   assign c = c2;

   function automatic logic [RW-1:0] rnext(input logic [RW-1:0] p);
      rnext = ({1'b0, p} + 1'b1 >= (RW+1)'(RING_DEPTH)) ? '0 : p + 1'b1;
   endfunction

   logic ring_full, ring_empty, line_room;
   assign ring_full  = rnext(tail_ff) == head_ff;
   assign ring_empty = head_ff == tail_ff;
   assign line_room  = len_ff < LCW'(LINE_DEPTH - 1);

   // decoded action of one request
   res_type    d_res [3];
   logic [1:0] d_n;
   logic       d_push, d_app, d_commit, d_eof_set, d_clr, d_dec;

   always_comb begin
      d_res[0] = '{KindEcho, 8'h00};
      d_res[1] = '{KindEcho, 8'h00};
      d_res[2] = '{KindEcho, 8'h00};
      d_n = 2'd0; d_push = 1'b0; d_app = 1'b0; d_commit = 1'b0;
      d_eof_set = 1'b0; d_clr = 1'b0; d_dec = 1'b0;
      if (req.cmd == CmdRead) begin
         d_n = 2'd1;
         if (!ring_empty) d_res[0] = '{KindData, 8'h00};
         else if (eof_ff) d_res[0] = '{KindEof, 8'h00};
         else d_res[0] = '{KindEmpty, 8'h00};
      end else if (sig_en && c0 == cfg.intr_char) begin
         d_n = 2'd1; d_res[0] = '{KindIntr, 8'h00};
      end else if (sig_en && c0 == cfg.susp_char) begin
         d_n = 2'd1; d_res[0] = '{KindSusp, 8'h00};
      end else if (ign) begin
         d_n = 2'd0;
      end else if (!canon) begin
         d_push = 1'b1;
         if (echo) begin d_n = 2'd1; d_res[0] = '{KindEcho, c}; end
      end else if (c == cfg.erase_char || c == ChBs) begin
         if (len_ff != '0) begin
            d_dec = 1'b1;
            if (echo && cfg.local_mode[3]) begin
               d_n = 2'd3;
               d_res[0] = '{KindEcho, ChBs};
               d_res[1] = '{KindEcho, ChSp};
               d_res[2] = '{KindEcho, ChBs};
            end
         end
      end else if (c == cfg.kill_char) begin
         d_clr = 1'b1;
         if (echo && cfg.local_mode[4]) begin
            d_n = 2'd3;
            d_res[0] = '{KindEcho, ChCaret};
            d_res[1] = '{KindEcho, ChU};
            d_res[2] = '{KindEcho, ChNl};
         end
      end else if (c == cfg.eof_char) begin
         if (len_ff == '0) d_eof_set = 1'b1;
         else d_commit = 1'b1;
      end else if (c == ChNl) begin
         d_app = line_room; d_commit = 1'b1;
         if (echo) begin d_n = 2'd1; d_res[0] = '{KindEcho, ChNl}; end
      end else begin
         d_app = line_room;
         if (echo) begin
            if (c < ChSp && c != ChNl && c != ChTab) begin
               d_n = 2'd2;
               d_res[0] = '{KindEcho, ChCaret};
               d_res[1] = '{KindEcho, c + CtlOffs};
            end else if (c != ChDel) begin
               d_n = 2'd1; d_res[0] = '{KindEcho, c};
            end
         end
      end
   end

   logic take, rsp_done, ring_we, cpy_go;
   assign req.ready = state_ff == ST_IDLE;
   assign take = req.valid && req.ready;
   assign rsp_done = rsp_valid_ff && rsp.ready;
   assign cpy_go = state_ff == ST_COPYW && cpy_ff < len_ff;
   assign ring_we = (take && d_push && !ring_full) || (cpy_go && !ring_full);

   // memories: line buffer and read ring
   always_ff @(posedge clock) begin
      if (take && d_app) line_mem[len_ff[LW-1:0]] <= c;
      if (state_ff == ST_COPY || cpy_go)
         line_rd_ff <= line_mem[cpy_ff[LW-1:0] + ((state_ff == ST_COPY) ? 1'b0 : 1'b1)];
      if (ring_we) ring_mem[tail_ff] <= take ? c : line_rd_ff;
      // read data is captured once and held while the response waits
      if (state_ff == ST_RDWAIT) ring_rd_ff <= ring_mem[head_ff];
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind  = res_ff[ridx_ff].kind;
   assign rsp.data  = (res_ff[ridx_ff].kind == KindData) ? ring_rd_ff : res_ff[ridx_ff].data;
   assign rsp.last  = ridx_ff == nres_ff - 2'd1;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0; tail_ff <= '0; len_ff <= '0; cpy_ff <= '0;
         eof_ff <= 1'b0; nres_ff <= '0; ridx_ff <= '0;
         commit_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         if (ring_we) tail_ff <= rnext(tail_ff);
         unique case (state_ff)
            ST_IDLE: if (take) begin
               res_ff <= d_res;
               nres_ff <= d_n;
               ridx_ff <= '0;
               commit_ff <= d_commit;
               cpy_ff <= '0;
               if (d_eof_set) eof_ff <= 1'b1;
               if (d_dec) len_ff <= len_ff - 1'b1;
               if (d_clr) len_ff <= '0;
               if (d_app) len_ff <= len_ff + 1'b1;
               if (req.cmd == CmdRead && ring_empty) eof_ff <= 1'b0;
               if (req.cmd == CmdRead) state_ff <= ST_RDWAIT;
               else if (d_n != '0) begin
                  rsp_valid_ff <= 1'b1; state_ff <= ST_EMIT;
               end else if (d_commit) state_ff <= ST_COPY;
            end
            ST_RDWAIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_EMIT;
               if (!ring_empty) head_ff <= rnext(head_ff);
            end
            ST_EMIT: if (rsp_done) begin
               if (ridx_ff == nres_ff - 2'd1) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= commit_ff ? ST_COPY : ST_IDLE;
               end else ridx_ff <= ridx_ff + 1'b1;
            end
            ST_COPY: state_ff <= ST_COPYW;
            ST_COPYW: begin
               if (cpy_go) cpy_ff <= cpy_ff + 1'b1;
               else begin
                  len_ff <= '0; commit_ff <= 1'b0; state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("ready during response");
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LCW'(LINE_DEPTH - 1)) else $error("line overflow");
   a_copy_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPYW |-> !rsp_valid_ff) else $error("response while copying");
   a_head_move: assert property (@(posedge clock) disable iff (reset)
      head_ff != $past(head_ff) |-> $past(state_ff) == ST_RDWAIT)
      else $error("head moved outside read");
endmodule
